FILE: design/tcw_pkg.sv
// Shared types and constants for the text console character writer.
// Holds the transfer payload structs, function and control-byte codes.
// No dependencies.
package tcw_pkg;

  // function codes of an input item
  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // control bytes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int TAB_STEP = 8;

  localparam logic [15:0] BLANK_RESET = 16'h0720;
  localparam logic [7:0]  ATTR_RESET  = 8'h07;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        scrolled;
    logic [15:0] cell_data;
  } out_item_t;

  // cursor unit decisions for one put
  typedef struct packed {
    logic write;
    logic scroll;
  } cur_ctl_t;

endpackage

FILE: design/tcw_cursor.sv
// Cursor update for one put: control-byte handling, column wrap, row overflow.
// Purely combinational; depends on tcw_pkg.
module tcw_cursor #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25,
  localparam int ROW_W = $clog2(ROWS),
  localparam int COL_W = $clog2(COLUMNS)
) (
  input  logic [ROW_W-1:0] row,
  input  logic [COL_W-1:0] col,
  input  logic [7:0]       char_code,
  output logic [ROW_W-1:0] row_next,
  output logic [COL_W-1:0] col_next,
  output tcw_pkg::cur_ctl_t ctl
);
  import tcw_pkg::*;

  localparam int CX_W = $clog2(COLUMNS + TAB_STEP);
  localparam int RX_W = $clog2(ROWS + 1);

  logic [CX_W-1:0] cx;
  logic [RX_W-1:0] rx;

  always_comb begin
    cx  = CX_W'(col);
    rx  = RX_W'(row);
    ctl = '0;
    case (char_code)
      CH_LF: begin
        cx = '0;
        rx = rx + RX_W'(1);
      end
      CH_CR: begin
        cx = '0;
      end
      CH_BS: begin
        if (cx != '0) begin
          cx = cx - CX_W'(1);
        end
      end
      CH_TAB: begin
        cx = (cx + CX_W'(TAB_STEP)) & ~CX_W'(TAB_STEP - 1);
      end
      default: begin
        ctl.write = 1'b1;
        cx = cx + CX_W'(1);
      end
    endcase
    // wrap past the last column
    if (cx >= CX_W'(COLUMNS)) begin
      cx = '0;
      rx = rx + RX_W'(1);
    end
    // past the last row: pin to the bottom and request a scroll
    if (rx >= RX_W'(ROWS)) begin
      ctl.scroll = 1'b1;
      rx = RX_W'(ROWS - 1);
    end
    row_next = rx[ROW_W-1:0];
    col_next = cx[COL_W-1:0];
  end

endmodule

FILE: design/text_console_char_writer.sv
// Text console character writer. After reset the screen store is swept to blank
// cells (0x0720), one cell a cycle, during which no item is taken; the attribute
// register may be written meanwhile. One item is worked at a time. A put that
// does not scroll, or an unused function, goes straight to completion; a read
// first passes through a read state that takes the registered store output. A
// clear blanks every cell, and a put that scrolls copies each row up by one and
// then blanks the bottom row, both through the single write port of the screen
// store, which copies or blanks one cell a cycle. A finished result waits in an
// output register while the next item is taken.
module text_console_char_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  tcw_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tcw_pkg::out_item_t out_data,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data
);
  import tcw_pkg::*;

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int IDX_W  = (ADDR_W > 11) ? ADDR_W : 11;

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SCROLL = 6'b000100,
    S_BLANK  = 6'b001000,
    S_READ   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [15:0] cells [CELLS];
  logic [15:0] rdata;
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [15:0]       wdata;

  logic [ROW_W-1:0]  row, row_put;
  logic [COL_W-1:0]  col, col_put;
  cur_ctl_t          ctl;
  logic [7:0]        color_attr;

  logic [ADDR_W-1:0] bptr, rptr;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;
  logic              scr;
  logic              rd_ok;
  logic [15:0]       rd_cell;

  logic              accept;
  logic [31:0]       row32, col32, pos32;
  logic [IDX_W-1:0]  idx_ext;
  logic              out_free;

  tcw_cursor #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_cursor (
    .row       (row),
    .col       (col),
    .char_code (in_data.char_code),
    .row_next  (row_put),
    .col_next  (col_put),
    .ctl       (ctl)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign row32    = 32'(row);
  assign col32    = 32'(col);
  assign pos32    = row32 * 32'(COLUMNS) + col32;
  assign idx_ext  = IDX_W'(in_data.cell_index);

  // screen store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      cells[waddr] <= wdata;
    end
    rdata <= cells[raddr];
  end

  // store port steering; a scroll copy lands in the cycle after its read, and the
  // write never hits the row being read, so no forwarding is needed
  always_comb begin
    we    = 1'b0;
    waddr = bptr;
    wdata = {color_attr, CH_SPACE};
    raddr = rptr;
    case (state)
      S_INIT: begin
        we    = 1'b1;
        wdata = BLANK_RESET;
      end
      S_IDLE: begin
        raddr = idx_ext[ADDR_W-1:0];
        waddr = pos32[ADDR_W-1:0];
        wdata = {color_attr, in_data.char_code};
        we    = accept && (in_data.func == FUNC_PUT) && ctl.write;
      end
      S_SCROLL: begin
        we    = pend;
        waddr = pend_addr;
        wdata = rdata;
      end
      S_BLANK: begin
        we = 1'b1;
        if (pend) begin
          waddr = pend_addr;
          wdata = rdata;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (bptr == ADDR_W'(CELLS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_data.func)
            FUNC_PUT:   state_next = ctl.scroll ? S_SCROLL : S_DONE;
            FUNC_CLEAR: state_next = S_BLANK;
            FUNC_READ:  state_next = S_READ;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_SCROLL: begin
        if (rptr == ADDR_W'(CELLS - 1)) begin
          state_next = S_BLANK;
        end
      end
      S_BLANK: begin
        if (!pend && bptr == ADDR_W'(CELLS - 1)) begin
          state_next = S_DONE;
        end
      end
      S_READ: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      row        <= '0;
      col        <= '0;
      color_attr <= ATTR_RESET;
      bptr       <= '0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == S_SCROLL);
      if (cfg_wr_en) begin
        color_attr <= cfg_wr_data;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          bptr <= bptr + ADDR_W'(1);
        end
        S_IDLE: begin
          if (accept) begin
            case (in_data.func)
              FUNC_PUT: begin
                row  <= row_put;
                col  <= col_put;
                bptr <= ADDR_W'(CELLS - COLUMNS);
              end
              FUNC_CLEAR: begin
                row  <= '0;
                col  <= '0;
                bptr <= '0;
              end
              default: begin
                bptr <= bptr;
              end
            endcase
          end
        end
        S_BLANK: begin
          // hold the pointer while the last scroll copy drains
          if (!pend) begin
            bptr <= bptr + ADDR_W'(1);
          end
        end
        default: begin
          bptr <= bptr;
        end
      endcase
    end
  end

  // item payload registers
  always_ff @(posedge clk) begin
    pend_addr <= rptr - ADDR_W'(COLUMNS);
    if (state == S_SCROLL) begin
      rptr <= rptr + ADDR_W'(1);
    end
    if (accept) begin
      rptr    <= ADDR_W'(COLUMNS);
      scr     <= (in_data.func == FUNC_PUT) && ctl.scroll;
      rd_cell <= '0;
      rd_ok   <= (idx_ext < IDX_W'(CELLS));
    end
    if (state == S_READ) begin
      rd_cell <= rd_ok ? rdata : '0;
    end
    if (state == S_DONE && out_free) begin
      out_data.cursor_pos <= pos32[10:0];
      out_data.cursor_row <= row32[4:0];
      out_data.cursor_col <= col32[6:0];
      out_data.scrolled   <= scr;
      out_data.cell_data  <= rd_cell;
    end
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (32'(row) < 32'(ROWS)) && (32'(col) < 32'(COLUMNS)))
    else $error("cursor left the screen");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("second item taken while one is in work");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside completion");

  a_scroll_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCROLL) |-> (32'(rptr) >= 32'(COLUMNS)))
    else $error("scroll read inside the top row");

endmodule
